>>> rtl/swfr_pkg.sv
// Shared constants, types and codes of the sliding window flow rate meter.
package swfr_pkg;

  localparam int WindowMax = 16;
  localparam int CntW = $clog2(WindowMax);
  localparam int SumW = $clog2((WindowMax - 1) * 65536);
  localparam int TsW = 48;
  localparam int RelW = 49;
  localparam int NodeW = 10;
  localparam int PortW = 16;
  localparam int BytesW = 16;
  localparam int TimeCfgW = 40;
  localparam int WinCfgW = 4;
  localparam int RateW = 32;
  localparam int CfgDataW = 40;
  localparam int CfgIdxW = 3;
  localparam int FracShift = 19;
  localparam int NumW = SumW + FracShift;
  localparam int DivCntW = $clog2(NumW);
  localparam int DivW = RelW;
  localparam int QueueDepth = 4;
  localparam int QPtrW = $clog2(QueueDepth);

  localparam logic [CfgIdxW-1:0] CfgMatchNode = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMatchPort = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTimeOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgWindowPackets = 3'd4;

  typedef logic signed [RelW-1:0] rel_t;

  typedef struct packed {
    logic [NodeW-1:0]    match_node;
    logic [PortW-1:0]    match_port;
    logic [TimeCfgW-1:0] time_offset_ns;
    logic [TimeCfgW-1:0] time_limit_ns;
    logic [WinCfgW-1:0]  window_packets;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    match_node:     10'd6,
    match_port:     16'd501,
    time_offset_ns: 40'd2000000000,
    time_limit_ns:  40'd30000000,
    window_packets: 4'd10
  };

  typedef struct packed {
    rel_t              rel;
    logic [BytesW-1:0] bytes;
  } pkt_t;

  typedef struct packed {
    logic             full;
    logic             valid;
    logic [QPtrW:0]   level;
  } q_stat_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_UPDATE,
    BE_PREP,
    BE_DIVIDE,
    BE_DONE
  } be_state_t;

endpackage

>>> rtl/swfr_if.sv
// Valid/ready stream interfaces for packet events and rate results.
interface swfr_event_if;
  import swfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [TsW-1:0]    timestamp_ns;
  logic [NodeW-1:0]  node_id;
  logic [PortW-1:0]  port_id;
  logic [BytesW-1:0] packet_bytes;

  modport source(output valid, timestamp_ns, node_id, port_id, packet_bytes, input ready);
  modport sink(input valid, timestamp_ns, node_id, port_id, packet_bytes, output ready);
endinterface

interface swfr_rate_if;
  import swfr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [RelW-1:0]  rel_time_ns;
  logic [RateW-1:0]        rate_gbps_q16;
  logic                    zero_interval;

  modport source(output valid, rel_time_ns, rate_gbps_q16, zero_interval, input ready);
  modport sink(input valid, rel_time_ns, rate_gbps_q16, zero_interval, output ready);
endinterface

>>> rtl/swfr_front.sv
// Front end: relative time, flow match and time limit check of each event.
module swfr_front (
  swfr_event_if.sink    events,
  input  swfr_pkg::cfg_t cfg,
  input  logic           q_full,
  output logic           q_push,
  output swfr_pkg::pkt_t q_data
);
  import swfr_pkg::*;

  rel_t rel;
  rel_t limit;
  logic hit;

  assign rel   = {1'b0, events.timestamp_ns} - {{(RelW-TimeCfgW){1'b0}}, cfg.time_offset_ns};
  assign limit = {{(RelW-TimeCfgW){1'b0}}, cfg.time_limit_ns};
  assign hit   = (events.node_id == cfg.match_node) && (events.port_id == cfg.match_port) &&
                 !(rel > limit);

  assign events.ready = !q_full;
  assign q_push       = events.valid && !q_full && hit;
  assign q_data       = '{rel: rel, bytes: events.packet_bytes};

endmodule

>>> rtl/swfr_queue.sv
// Short queue of matching packets between the front end and the back end.
module swfr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  swfr_pkg::pkt_t   push_data,
  input  logic             pop,
  output swfr_pkg::pkt_t   pop_data,
  output swfr_pkg::q_stat_t stat
);
  import swfr_pkg::*;

  pkt_t             entries [QueueDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   level;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (level == (QPtrW+1)'(QueueDepth));
  assign stat.valid = (level != '0);
  assign stat.level = level;
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        level <= level + 1'b1;
      end else if (do_pop && !do_push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

>>> rtl/swfr_back.sv
// Back end: window FIFO and byte sum update, bit-serial rate division, result register.
module swfr_back (
  input  logic              clk,
  input  logic              rst,
  input  swfr_pkg::cfg_t    cfg,
  input  swfr_pkg::q_stat_t q_stat,
  input  swfr_pkg::pkt_t    q_data,
  output logic              q_pop,
  swfr_rate_if.source       rates
);
  import swfr_pkg::*;

  be_state_t state;
  be_state_t state_next;

  rel_t              window_times [WindowMax];
  logic [BytesW-1:0] window_sizes [WindowMax];
  rel_t              rd_time;
  logic [BytesW-1:0] rd_size;

  logic [CntW-1:0] window_count;
  logic [CntW-1:0] window_head;
  logic [SumW-1:0] byte_sum;
  rel_t            base_time;

  rel_t              cur_rel;
  logic [BytesW-1:0] cur_bytes;

  logic [DivW-1:0]    divisor;
  logic [DivW-1:0]    rem;
  logic [NumW-1:0]    num_sh;
  logic [NumW-1:0]    quo;
  logic [DivCntW-1:0] div_cnt;
  logic               zero_flag;

  logic               out_valid;
  rel_t               out_rel;
  logic [RateW-1:0]   out_rate;
  logic               out_zero;

  logic            load_out;
  logic [8:0]      wp_ext;
  logic [8:0]      eff9;
  logic            drop;
  logic [CntW:0]   slot_sum;
  logic [CntW:0]   slot_wrap;
  logic [CntW-1:0] slot;
  logic [RelW:0]   dt;
  logic            dt_nonpos;
  logic [DivW:0]   shifted;
  logic [DivW+1:0] diff;
  logic [RateW-1:0] rate_sat;

  localparam logic [8:0] Cap = 9'(WindowMax - 1);

  assign wp_ext    = {{(9-WinCfgW){1'b0}}, cfg.window_packets};
  assign eff9      = (wp_ext == '0) ? 9'd1 : ((wp_ext > Cap) ? Cap : wp_ext);
  assign drop      = ({{(9-CntW){1'b0}}, window_count} >= eff9);
  assign slot_sum  = {1'b0, window_head} + {1'b0, window_count};
  assign slot_wrap = (slot_sum >= (CntW+1)'(WindowMax)) ? slot_sum - (CntW+1)'(WindowMax)
                                                         : slot_sum;
  assign slot      = slot_wrap[CntW-1:0];

  assign dt        = {cur_rel[RelW-1], cur_rel} - {base_time[RelW-1], base_time};
  assign dt_nonpos = dt[RelW] || (dt == '0);

  assign shifted   = {rem, num_sh[NumW-1]};
  assign diff      = {1'b0, shifted} - {2'b00, divisor};

  assign rate_sat  = zero_flag ? '0 :
                     ((quo[NumW-1:RateW] != '0) ? {RateW{1'b1}} : quo[RateW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    load_out   = 1'b0;
    case (state)
      BE_IDLE: begin
        if (q_stat.valid) begin
          q_pop      = 1'b1;
          state_next = BE_UPDATE;
        end
      end
      BE_UPDATE: state_next = BE_PREP;
      BE_PREP: state_next = dt_nonpos ? BE_DONE : BE_DIVIDE;
      BE_DIVIDE: begin
        if (div_cnt == '0) begin
          state_next = BE_DONE;
        end
      end
      BE_DONE: begin
        if (!out_valid || rates.ready) begin
          load_out   = 1'b1;
          state_next = BE_IDLE;
        end
      end
      default: state_next = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_time <= window_times[window_head];
    rd_size <= window_sizes[window_head];
    if (state == BE_UPDATE) begin
      window_times[slot] <= cur_rel;
      window_sizes[slot] <= cur_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      window_head  <= '0;
      byte_sum     <= '0;
      base_time    <= '0;
    end else if (state == BE_UPDATE) begin
      if (drop) begin
        byte_sum    <= byte_sum + {{(SumW-BytesW){1'b0}}, cur_bytes} -
                       {{(SumW-BytesW){1'b0}}, rd_size};
        base_time   <= rd_time;
        window_head <= (window_head == CntW'(WindowMax - 1)) ? '0 : window_head + 1'b1;
      end else begin
        byte_sum     <= byte_sum + {{(SumW-BytesW){1'b0}}, cur_bytes};
        window_count <= window_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BE_IDLE: begin
        cur_rel   <= q_data.rel;
        cur_bytes <= q_data.bytes;
      end
      BE_PREP: begin
        zero_flag <= dt_nonpos;
        divisor   <= dt[DivW-1:0];
        rem       <= '0;
        num_sh    <= {byte_sum, {FracShift{1'b0}}};
        quo       <= '0;
        div_cnt   <= DivCntW'(NumW - 1);
      end
      BE_DIVIDE: begin
        if (!diff[DivW+1]) begin
          rem <= diff[DivW-1:0];
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= shifted[DivW-1:0];
          quo <= {quo[NumW-2:0], 1'b0};
        end
        num_sh  <= {num_sh[NumW-2:0], 1'b0};
        div_cnt <= div_cnt - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rates.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_rel  <= cur_rel;
      out_rate <= rate_sat;
      out_zero <= zero_flag;
    end
  end

  assign rates.valid         = out_valid;
  assign rates.rel_time_ns   = out_rel;
  assign rates.rate_gbps_q16 = out_rate;
  assign rates.zero_interval = out_zero;

endmodule

>>> rtl/sliding_window_flow_rate_meter.sv
// Top level of the sliding window flow rate meter: config registers, queue and the two ends.
// The meter takes one packet event per cycle on events while its four-entry packet queue has
// room; events of other flows or beyond the time limit are consumed in that cycle and give no
// result. Each matching packet then goes through the back end step by step: it leaves the
// queue, the window FIFO and byte sum are updated, the interval is formed, NumW steps of
// the one-bit-per-cycle restoring divider run, and the result register is loaded, which
// holds a finished result while the next packet is worked on. A packet whose interval is
// zero or negative skips the divider. A finished result waits in the back end while the
// result register still holds an untaken transfer. The divider sets the sustained rate of
// matching packets. Configuration is written through cfg_we, cfg_index and cfg_data and
// takes effect at the next clock edge.
module sliding_window_flow_rate_meter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [swfr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [swfr_pkg::CfgDataW-1:0]  cfg_data,
  swfr_event_if.sink                     events,
  swfr_rate_if.source                    rates
);
  import swfr_pkg::*;

  cfg_t    cfg;
  logic    q_push;
  pkt_t    q_in;
  logic    q_pop;
  pkt_t    q_out;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CfgReset;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgMatchNode:     cfg.match_node     <= cfg_data[NodeW-1:0];
        CfgMatchPort:     cfg.match_port     <= cfg_data[PortW-1:0];
        CfgTimeOffset:    cfg.time_offset_ns <= cfg_data[TimeCfgW-1:0];
        CfgTimeLimit:     cfg.time_limit_ns  <= cfg_data[TimeCfgW-1:0];
        CfgWindowPackets: cfg.window_packets <= cfg_data[WinCfgW-1:0];
        default: ;
      endcase
    end
  end

  swfr_front u_front (
    .events (events),
    .cfg    (cfg),
    .q_full (q_stat.full),
    .q_push (q_push),
    .q_data (q_in)
  );

  swfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  swfr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_stat (q_stat),
    .q_data (q_out),
    .q_pop  (q_pop),
    .rates  (rates)
  );

`ifndef SYNTH
  // A zero or negative interval always reports a zero rate.
  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    rates.valid && rates.zero_interval |-> rates.rate_gbps_q16 == '0)
    else $error("zero interval result with nonzero rate");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("push into full packet queue");

  // An event of another node never adds a queue entry.
  a_reject_node: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.ready && (events.node_id != cfg.match_node)
    |=> q_stat.level <= $past(q_stat.level))
    else $error("rejected event entered the packet queue");
`endif

endmodule

>>> sim/swfr_checker.sv
// Checker that mirrors the meter's window state and compares every rate result.
module swfr_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [swfr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swfr_pkg::CfgDataW-1:0] cfg_data,
  swfr_event_if                         events,
  swfr_rate_if                          rates,
  input  logic                          end_check,
  output int                            fail_count,
  output int                            pending,
  output int                            matched_count,
  output int                            checked_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import swfr_pkg::*;

  typedef struct {
    rel_t             rel;
    logic [RateW-1:0] rate;
    logic             zero;
  } rate_result_t;

  cfg_t              meter_cfg;
  longint            win_time [WindowMax];
  logic [BytesW-1:0] win_bytes [WindowMax];
  int unsigned       win_count;
  int unsigned       win_head;
  longint unsigned   byte_total;
  longint            base_time;
  rate_result_t      expected_rates [$];
  rate_result_t      want;
  int                errors = 0;
  int                n_matched = 0;
  int                n_checked = 0;

  task automatic report(input string msg);
    errors++;
    if (errors <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  task automatic measure_packet(input logic [TsW-1:0] ts, input logic [NodeW-1:0] node,
                                input logic [PortW-1:0] port, input logic [BytesW-1:0] bytes);
    longint          rel_now;
    longint          dt;
    longint unsigned num;
    longint unsigned quot;
    int unsigned     slot;
    int unsigned     eff;
    rate_result_t    res;
    rel_now = $signed({16'd0, ts}) - $signed({24'd0, meter_cfg.time_offset_ns});
    if (node != meter_cfg.match_node || port != meter_cfg.match_port) return;
    if (rel_now > $signed({24'd0, meter_cfg.time_limit_ns})) return;
    slot = (win_head + win_count) % WindowMax;
    win_time[slot] = rel_now;
    win_bytes[slot] = bytes;
    win_count++;
    byte_total += bytes;
    eff = (meter_cfg.window_packets == 0) ? 1 : meter_cfg.window_packets;
    if (eff > WindowMax - 1) eff = WindowMax - 1;
    if (win_count > eff) begin
      byte_total -= win_bytes[win_head];
      base_time = win_time[win_head];
      win_head = (win_head + 1) % WindowMax;
      win_count--;
    end
    dt = rel_now - base_time;
    res.rel = rel_now[RelW-1:0];
    if (dt <= 0) begin
      res.zero = 1'b1;
      res.rate = '0;
    end else begin
      res.zero = 1'b0;
      num = (byte_total * 8) << 16;
      quot = num / dt;
      res.rate = (quot > 64'hFFFF_FFFF) ? '1 : quot[RateW-1:0];
    end
    expected_rates.insert(expected_rates.size(), res);
    n_matched++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      meter_cfg = CfgReset;
      win_count = 0;
      win_head = 0;
      byte_total = 0;
      base_time = 0;
      expected_rates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgMatchNode:     meter_cfg.match_node = cfg_data[NodeW-1:0];
          CfgMatchPort:     meter_cfg.match_port = cfg_data[PortW-1:0];
          CfgTimeOffset:    meter_cfg.time_offset_ns = cfg_data[TimeCfgW-1:0];
          CfgTimeLimit:     meter_cfg.time_limit_ns = cfg_data[TimeCfgW-1:0];
          CfgWindowPackets: meter_cfg.window_packets = cfg_data[WinCfgW-1:0];
          default: ;
        endcase
      end
      if (rates.valid && rates.ready) begin
        if (expected_rates.size() == 0) begin
          report($sformatf("result with no packet waiting: rel %0d rate %0h",
                           $signed(rates.rel_time_ns), rates.rate_gbps_q16));
        end else begin
          want = expected_rates.pop_front();
          n_checked++;
          if (rates.rel_time_ns !== want.rel) begin
            report($sformatf("rel_time_ns %0d, expected %0d",
                             $signed(rates.rel_time_ns), want.rel));
          end
          if (rates.rate_gbps_q16 !== want.rate) begin
            report($sformatf("rate_gbps_q16 %0h, expected %0h at rel %0d",
                             rates.rate_gbps_q16, want.rate, want.rel));
          end
          if (rates.zero_interval !== want.zero) begin
            report($sformatf("zero_interval %b, expected %b at rel %0d",
                             rates.zero_interval, want.zero, want.rel));
          end
        end
      end
      if (events.valid && events.ready) begin
        measure_packet(events.timestamp_ns, events.node_id, events.port_id,
                       events.packet_bytes);
      end
      if (end_check && expected_rates.size() != 0) begin
        report($sformatf("%0d rate results never arrived", expected_rates.size()));
      end
    end
    fail_count <= errors;
    pending <= expected_rates.size();
    matched_count <= n_matched;
    checked_count <= n_checked;
  end

endmodule

>>> sim/tb_top.sv
// Testbench top of the flow rate meter: clock, reset, register setup, packet stimulus, verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swfr_pkg::*;

  typedef struct {
    logic [TsW-1:0]    ts;
    logic [NodeW-1:0]  node;
    logic [PortW-1:0]  port;
    logic [BytesW-1:0] bytes;
  } pkt_event_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                end_check;
  int                  fail_count;
  int                  pending;
  int                  matched_count;
  int                  checked_count;

  cfg_t   cur_cfg = CfgReset;
  longint flow_rel = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_req = 1'b0;
  int     hold_left = 0;
  int     sent_events = 0;
  int     settings_used = 1;

  swfr_event_if ev_if ();
  swfr_rate_if  rt_if ();

  sliding_window_flow_rate_meter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .events    (ev_if),
    .rates     (rt_if)
  );

  swfr_checker rate_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .events        (ev_if),
    .rates         (rt_if),
    .end_check     (end_check),
    .fail_count    (fail_count),
    .pending       (pending),
    .matched_count (matched_count),
    .checked_count (checked_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d rate results outstanding.", pending);
    $display("TEST FAILED");
    $finish;
  end

  // The long hold-off is counted here so that the sender keeps offering packets meanwhile.
  initial begin
    rt_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        rt_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 499;
        rt_if.ready <= 1'b0;
      end else begin
        rt_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
  endtask

  task automatic program_meter(input cfg_t c);
    logic [CfgDataW-1:0] d;
    d = CfgDataW'({$urandom, $urandom});
    d[NodeW-1:0] = c.match_node;
    write_reg(CfgMatchNode, d);
    d = CfgDataW'({$urandom, $urandom});
    d[PortW-1:0] = c.match_port;
    write_reg(CfgMatchPort, d);
    write_reg(CfgTimeOffset, c.time_offset_ns);
    write_reg(CfgTimeLimit, c.time_limit_ns);
    d = CfgDataW'({$urandom, $urandom});
    d[WinCfgW-1:0] = c.window_packets;
    write_reg(CfgWindowPackets, d);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cfg = c;
    flow_rel = 0;
    settings_used++;
  endtask

  task automatic send_event(input pkt_event_t e);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_if.valid <= 1'b1;
    ev_if.timestamp_ns <= e.ts;
    ev_if.node_id <= e.node;
    ev_if.port_id <= e.port;
    ev_if.packet_bytes <= e.bytes;
    do @(posedge clk); while (!ev_if.ready);
    sent_events++;
  endtask

  task automatic wait_idle();
    ev_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic pkt_event_t flow_pkt(input longint rel, input logic [BytesW-1:0] bytes);
    pkt_event_t e;
    longint     ts;
    ts = rel + $signed({24'd0, CfgReset.time_offset_ns});
    e.ts = ts[TsW-1:0];
    e.node = CfgReset.match_node;
    e.port = CfgReset.match_port;
    e.bytes = bytes;
    return e;
  endfunction

  // Mostly packets of the programmed flow on a wandering clock, the rest off-flow or late.
  function automatic pkt_event_t random_event();
    pkt_event_t      e;
    longint          lo;
    longint          hi;
    longint          span;
    longint          ts;
    longint unsigned rnd;
    int unsigned     r;
    int unsigned     s;
    lo = -$signed({24'd0, cur_cfg.time_offset_ns});
    hi = $signed({24'd0, cur_cfg.time_limit_ns});
    span = hi - lo;
    rnd = {$urandom, $urandom};
    s = $urandom_range(0, 99);
    if (s < 40) flow_rel += $urandom_range(0, 20);
    else if (s < 75) flow_rel += $urandom_range(0, 200000);
    else if (s < 85) flow_rel += ($urandom & 32'h00FF_FFFF);
    else if (s < 92) flow_rel -= $urandom_range(0, 1000);
    else flow_rel = lo + longint'(rnd % (span + 1));
    if (flow_rel > hi) flow_rel = lo + longint'(rnd % (span + 1));
    if (flow_rel < lo) flow_rel = lo;
    ts = flow_rel - lo;
    e.ts = ts[TsW-1:0];
    e.node = cur_cfg.match_node;
    e.port = cur_cfg.match_port;
    case ($urandom_range(0, 9))
      0: e.bytes = '0;
      1: e.bytes = '1;
      default: e.bytes = BytesW'($urandom);
    endcase
    r = $urandom_range(0, 99);
    if (r >= 95) begin
      rnd = {$urandom, $urandom};
      e.ts = rnd[TsW-1:0];
      e.node = NodeW'($urandom);
      e.port = PortW'($urandom);
    end else if (r >= 90) begin
      ts = hi + 1 + $urandom_range(0, 1000000) - lo;
      e.ts = ts[TsW-1:0];
    end else if (r >= 84) begin
      e.port = PortW'($urandom);
    end else if (r >= 78) begin
      e.node = NodeW'($urandom);
    end
    return e;
  endfunction

  initial begin
    cfg_t c;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CfgMatchNode;
    cfg_data <= '0;
    end_check <= 1'b0;
    ev_if.valid <= 1'b0;
    ev_if.timestamp_ns <= '0;
    ev_if.node_id <= '0;
    ev_if.port_id <= '0;
    ev_if.packet_bytes <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_event(flow_pkt(0, 16'd100));
    send_event(flow_pkt(-5, 16'd200));
    send_event(flow_pkt(1, 16'hFFFF));
    send_event(flow_pkt(2, 16'd0));
    send_event('{48'd2000000010, 10'd7, 16'd501, 16'd1000});
    send_event('{48'd2000000010, 10'd6, 16'd502, 16'd1000});
    send_event(flow_pkt(30000001, 16'd500));
    send_event(flow_pkt(30000000, 16'd500));
    send_event('{48'd0, 10'd6, 16'd501, 16'd1234});
    send_event('{48'hFFFF_FFFF_FFFF, 10'd6, 16'd501, 16'hFFFF});
    send_event('{48'd2000000020, 10'h3FF, 16'hFFFF, 16'h5555});
    for (int i = 0; i < 12; i++) begin
      send_event(flow_pkt(1000 + i * i * 37, BytesW'($urandom)));
    end
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: c = '{10'h3FF, 16'hFFFF, '1, '1, 4'd15};
        1: c = '{10'd0, 16'd0, 40'd0, '1, 4'd1};
        2: c = '{10'($urandom), 16'($urandom), 40'd1000000, 40'd0, 4'd0};
        default: begin
          c.match_node = NodeW'($urandom);
          c.match_port = PortW'($urandom);
          c.time_offset_ns = TimeCfgW'({$urandom, $urandom});
          c.time_limit_ns = TimeCfgW'({$urandom, $urandom});
          c.window_packets = WinCfgW'($urandom);
        end
      endcase
      program_meter(c);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      for (int i = 0; i < 170; i++) begin
        if (p == 2 && i == 20) hold_req = 1'b1;
        send_event(random_event());
      end
      wait_idle();
    end

    end_check <= 1'b1;
    @(posedge clk);
    end_check <= 1'b0;
    repeat (3) @(posedge clk);
    $display("Covered %0d packet events over %0d register settings; %0d belonged to the flow.",
             sent_events, settings_used, matched_count);
    $display("Checked %0d rate results through window refills, shrinks and receiver stalls.",
             checked_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
